// ===== rtl/mmt_pkg.sv =====
// Shared constants and types for the transposed matrix multiply block.
package mmt_pkg;

  localparam int DIM    = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DIM);
  localparam int CNT_W  = $clog2(DIM + 1);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int RC_W   = 5;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // one term of a dot product, travelling with its operands
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_term;
    logic             last_res;
    logic [IDX_W-1:0] col;
  } term_t;

  // one finished dot product
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] sum;
  } res_t;

endpackage

// ===== rtl/mmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/mmt_mac.sv =====
// Shared multiply-accumulate unit: product register, accumulator, result register.
module mmt_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mmt_pkg::term_t            term,
  input  logic [mmt_pkg::DATA_W-1:0] a_data,
  input  logic [mmt_pkg::DATA_W-1:0] b_data,
  output mmt_pkg::res_t             res
);

  logic [mmt_pkg::DATA_W-1:0] prod_r;
  mmt_pkg::term_t             term_r;
  logic [mmt_pkg::DATA_W-1:0] acc_r;
  logic [mmt_pkg::DATA_W-1:0] acc_nxt;
  mmt_pkg::res_t              res_r;
  logic [mmt_pkg::DATA_W-1:0] full_prod;

  // only the low word of each product is kept
  assign full_prod = a_data * b_data;
  assign acc_nxt   = term_r.first ? prod_r : acc_r + prod_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r.valid <= 1'b0;
      res_r.valid  <= 1'b0;
    end else begin
      term_r.valid <= term.valid;
      res_r.valid  <= term_r.valid && term_r.last_term;
    end
    term_r.first     <= term.first;
    term_r.last_term <= term.last_term;
    term_r.last_res  <= term.last_res;
    term_r.col       <= term.col;
    prod_r           <= full_prod;
    if (term_r.valid) begin
      acc_r <= acc_nxt;
    end
    res_r.sum  <= acc_nxt;
    res_r.col  <= term_r.col;
    res_r.last <= term_r.last_res;
  end

endmodule

// ===== rtl/matrix_multiply_transposed.sv =====
// Top level: element stores, row/column sequencer and result port.
// Loads (cmd 0) are taken whenever the block is idle and never raise busy. A compute (cmd 1) for a row
// below the effective row count n (row_count clamped to 1..16) keeps busy high until
// its last result is out: the single shared 32x32 multiply-accumulate unit takes one term per
// cycle, so n results come out, one per column k.
// Each result is strobed on out_valid for one cycle and must be taken then; the
// receiver cannot hold it off. A compute for a row at or beyond n gives no results and
// leaves busy low.
module matrix_multiply_transposed (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic [3:0]                   in_row,
  input  logic [3:0]                   in_col,
  input  logic [31:0]                  in_a_value,
  input  logic [31:0]                  in_b_value,
  output logic                         out_valid,
  output logic [31:0]                  out_product_sum,
  output logic [3:0]                   out_col,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [mmt_pkg::RC_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t                      state_r;
  logic [mmt_pkg::RC_W-1:0]    row_count_r;
  logic [mmt_pkg::CNT_W-1:0]   n_eff;
  logic [mmt_pkg::CNT_W-1:0]   n_r;
  logic [mmt_pkg::IDX_W-1:0]   row_r;
  logic [mmt_pkg::IDX_W-1:0]   k_r;
  logic [mmt_pkg::IDX_W-1:0]   i_r;
  logic                        accept;
  logic                        wr_en;
  logic                        i_last;
  logic                        k_last;
  logic [mmt_pkg::ADDR_W-1:0]  wr_addr;
  logic [mmt_pkg::ADDR_W-1:0]  rd_addr_a;
  logic [mmt_pkg::ADDR_W-1:0]  rd_addr_b;
  logic [mmt_pkg::DATA_W-1:0]  a_data;
  logic [mmt_pkg::DATA_W-1:0]  b_data;
  mmt_pkg::term_t              term_nxt;
  mmt_pkg::term_t              term_r;
  mmt_pkg::res_t               res;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (row_count_r == '0) begin
      n_eff = mmt_pkg::CNT_W'(1);
    end else if (32'(row_count_r) > 32'(mmt_pkg::DIM)) begin
      n_eff = mmt_pkg::CNT_W'(mmt_pkg::DIM);
    end else begin
      n_eff = mmt_pkg::CNT_W'(row_count_r);
    end
  end

  assign wr_en = accept && (in_cmd == mmt_pkg::CMD_LOAD) &&
                 (32'(in_row) < 32'(mmt_pkg::DIM)) && (32'(in_col) < 32'(mmt_pkg::DIM));
  assign wr_addr   = {mmt_pkg::IDX_W'(in_row), mmt_pkg::IDX_W'(in_col)};
  assign rd_addr_a = {row_r, i_r};
  assign rd_addr_b = {k_r, i_r};

  assign i_last = (i_r == mmt_pkg::IDX_W'(mmt_pkg::DIM - 1));
  assign k_last = ((mmt_pkg::CNT_W'(k_r) + mmt_pkg::CNT_W'(1)) == n_r);

  always_comb begin
    term_nxt.valid     = (state_r == ST_RUN);
    term_nxt.first     = (i_r == '0);
    term_nxt.last_term = i_last;
    term_nxt.last_res  = k_last;
    term_nxt.col       = k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= mmt_pkg::RC_W'(16);
    end else if (cfg_we) begin
      row_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      term_r.valid <= 1'b0;
      k_r          <= '0;
      i_r          <= '0;
    end else begin
      // term control lines up with the registered RAM read data
      term_r <= term_nxt;
      case (state_r)
        ST_IDLE: begin
          if (accept && (in_cmd == mmt_pkg::CMD_COMPUTE) && (32'(in_row) < 32'(n_eff))) begin
            state_r <= ST_RUN;
            row_r   <= mmt_pkg::IDX_W'(in_row);
            n_r     <= n_eff;
            k_r     <= '0;
            i_r     <= '0;
          end
        end
        ST_RUN: begin
          if (i_last) begin
            i_r <= '0;
            if (k_last) begin
              state_r <= ST_DRAIN;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (res.valid && res.last) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  mmt_ram #(
    .WIDTH(mmt_pkg::DATA_W),
    .DEPTH(mmt_pkg::DIM * mmt_pkg::DIM)
  ) u_ram_a (
    .clk    (clk),
    .we     (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_a_value),
    .rd_addr(rd_addr_a),
    .rd_data(a_data)
  );

  mmt_ram #(
    .WIDTH(mmt_pkg::DATA_W),
    .DEPTH(mmt_pkg::DIM * mmt_pkg::DIM)
  ) u_ram_b (
    .clk    (clk),
    .we     (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_b_value),
    .rd_addr(rd_addr_b),
    .rd_data(b_data)
  );

  mmt_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .term  (term_r),
    .a_data(a_data),
    .b_data(b_data),
    .res   (res)
  );

  assign out_valid       = res.valid;
  assign out_product_sum = res.sum;
  assign out_col         = 4'(res.col);
  assign out_last        = res.last;

  // results only come out of an accepted compute
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // final result of a row releases the block
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !busy)
    else $error("busy held after final result");

  // an in-range compute transfer starts the sequencer
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == mmt_pkg::CMD_COMPUTE) && (32'(in_row) < 32'(n_eff)))
      |=> (state_r == ST_RUN))
    else $error("compute transfer did not start");

  // no store write while a row is being computed
  a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !wr_en)
    else $error("store written while busy");

endmodule

// ===== sim/matrix_multiply_transposed_tb.sv =====
// Self-checking testbench for the transposed matrix multiply block.
`timescale 1ns / 100ps

module matrix_multiply_transposed_tb;

  localparam int QUIET_LIMIT  = 1000;  // cycles with no transfer and no result
  localparam int SETTLE_CYCLES = 8;    // pause before a row_count write
  localparam int DRAIN_CYCLES  = 40;   // watch for stray results at the end
  localparam int PHASE_ITEMS   = 2;

  typedef struct {
    logic [31:0] sum;
    logic [3:0]  col;
    logic        last;
  } dot_res_t;

  // typed-in expectation for one item; known == 0 means use the predictor
  typedef struct {
    logic        known;
    logic [31:0] sum;
  } item_tag_t;

  typedef struct {
    logic        cmd;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] a;
    logic [31:0] b;
    logic        known;
    logic [31:0] sum;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_cmd;
  logic [3:0]        in_row;
  logic [3:0]        in_col;
  logic [31:0]       in_a_value;
  logic [31:0]       in_b_value;
  logic              out_valid;
  logic [31:0]       out_product_sum;
  logic [3:0]        out_col;
  logic              out_last;
  logic              cfg_we;
  logic [mmt_pkg::RC_W-1:0] cfg_data;

  matrix_multiply_transposed dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_a_value      (in_a_value),
    .in_b_value      (in_b_value),
    .out_valid       (out_valid),
    .out_product_sum (out_product_sum),
    .out_col         (out_col),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data)
  );

  // predictor state
  logic [31:0]     a_store  [mmt_pkg::DIM][mmt_pkg::DIM];
  logic [31:0]     bt_store [mmt_pkg::DIM][mmt_pkg::DIM];
  logic [mmt_pkg::RC_W-1:0] row_count_q;

  dot_res_t  pending_dots[$];
  item_tag_t item_tags[$];
  int        error_count;
  int        quiet_cycles = 0;

  // stimulus side bookkeeping
  bit        filled [mmt_pkg::DIM][mmt_pkg::DIM];
  bit        burst;
  int        cur_rows;
  stim_row_t directed[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int rows_in_use(logic [mmt_pkg::RC_W-1:0] rc);
    if (rc == 0) return 1;
    if (rc > mmt_pkg::DIM) return mmt_pkg::DIM;
    return int'(rc);
  endfunction

  function automatic logic [31:0] row_dot(int r, int k);
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < mmt_pkg::DIM; i++) begin
      acc = acc + a_store[r][i] * bt_store[k][i];
    end
    return acc;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  task automatic report(input string msg);
    if (error_count < 50) $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // result check first, then prediction for this edge's transfer
  always @(posedge clk) begin : monitor
    dot_res_t  want;
    item_tag_t tag;
    int        n;
    if (!rst_n) begin
      row_count_q = 5'd16;
    end else begin
      if (out_valid) begin
        if (pending_dots.size() == 0) begin
          report($sformatf("result with nothing expected: sum %h col %0d last %b",
                           out_product_sum, out_col, out_last));
        end else begin
          want = pending_dots.pop_front();
          if (out_product_sum !== want.sum)
            report($sformatf("col %0d sum %h, want %h", want.col, out_product_sum, want.sum));
          if (out_col !== want.col)
            report($sformatf("out_col %0d, want %0d", out_col, want.col));
          if (out_last !== want.last)
            report($sformatf("col %0d last %b, want %b", want.col, out_last, want.last));
        end
      end
      if (cfg_we) row_count_q = cfg_data;
      if (start && !busy) begin
        tag.known = 1'b0;
        tag.sum   = '0;
        if (item_tags.size() != 0) tag = item_tags.pop_front();
        if (in_cmd == mmt_pkg::CMD_LOAD) begin
          a_store[in_row][in_col]  = in_a_value;
          bt_store[in_row][in_col] = in_b_value;
        end else begin
          n = rows_in_use(row_count_q);
          if (int'(in_row) < n) begin
            for (int k = 0; k < n; k++) begin
              want.sum  = tag.known ? tag.sum : row_dot(in_row, k);
              want.col  = 4'(k);
              want.last = (k == n - 1);
              pending_dots.push_back(want);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_item(input logic cmd, input logic [3:0] row, input logic [3:0] col,
                           input logic [31:0] a, input logic [31:0] b,
                           input logic known, input logic [31:0] sum);
    int        gap;
    item_tag_t tag;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tag.known = known;
    tag.sum   = sum;
    item_tags.push_back(tag);
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_row     <= row;
    in_col     <= col;
    in_a_value <= a;
    in_b_value <= b;
    do @(posedge clk); while (busy);
    if (cmd == mmt_pkg::CMD_LOAD) filled[row][col] = 1'b1;
  endtask

  task automatic write_row_count(input logic [mmt_pkg::RC_W-1:0] value);
    start <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_rows = rows_in_use(value);
  endtask

  task automatic random_item();
    logic [3:0] row;
    if ($urandom_range(0, 1) == 0) begin
      send_item(mmt_pkg::CMD_LOAD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                rand_word(), rand_word(), 1'b0, '0);
    end else begin
      row = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, cur_rows - 1))
                                        : 4'($urandom_range(0, 15));
      send_item(mmt_pkg::CMD_COMPUTE, row, 4'($urandom_range(0, 15)), rand_word(),
                rand_word(), 1'b0, '0);
    end
  endtask

  initial begin
    int rc_plan[9];
    stim_row_t s;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_cmd      = mmt_pkg::CMD_LOAD;
    in_row      = '0;
    in_col      = '0;
    in_a_value  = '0;
    in_b_value  = '0;
    cfg_we      = 1'b0;
    cfg_data    = '0;
    error_count = 0;
    burst       = 1'b0;
    cur_rows    = mmt_pkg::DIM;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single result row: only row 0 of both stores is read
    write_row_count(5'd1);

    // all-ones rows: each product wraps to 1, sixteen of them
    for (int c = 0; c < mmt_pkg::DIM; c++)
      directed.push_back('{mmt_pkg::CMD_LOAD, 4'd0, 4'(c), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           1'b0, 32'd0});
    directed.push_back('{mmt_pkg::CMD_COMPUTE, 4'd0,  4'd0,  32'd0, 32'd0, 1'b1, 32'd16});
    // rows past the row count give nothing
    directed.push_back('{mmt_pkg::CMD_COMPUTE, 4'd1,  4'd15, 32'hFFFF_FFFF, 32'd0,
                         1'b0, 32'd0});
    directed.push_back('{mmt_pkg::CMD_COMPUTE, 4'd15, 4'd7,  32'd0, 32'hFFFF_FFFF,
                         1'b0, 32'd0});
    directed.push_back('{mmt_pkg::CMD_LOAD,    4'd0,  4'd15, 32'd0, 32'hFFFF_FFFF,
                         1'b0, 32'd0});
    directed.push_back('{mmt_pkg::CMD_COMPUTE, 4'd0,  4'd9,  32'd0, 32'd0, 1'b1, 32'd15});
    directed.push_back('{mmt_pkg::CMD_LOAD,    4'd15, 4'd0,  32'h1234_5678, 32'h9ABC_DEF0,
                         1'b0, 32'd0});
    // product wraps to zero
    directed.push_back('{mmt_pkg::CMD_LOAD,    4'd0,  4'd0,  32'h8000_0000, 32'd2,
                         1'b0, 32'd0});
    directed.push_back('{mmt_pkg::CMD_COMPUTE, 4'd0,  4'd3,  32'd0, 32'd0, 1'b1, 32'd14});
    directed.push_back('{mmt_pkg::CMD_LOAD,    4'd0,  4'd1,  32'd3, 32'd5, 1'b0, 32'd0});
    directed.push_back('{mmt_pkg::CMD_COMPUTE, 4'd0,  4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         1'b0, 32'd0});

    foreach (directed[i]) begin
      s = directed[i];
      send_item(s.cmd, s.row, s.col, s.a, s.b, s.known, s.sum);
    end

    // register sweep: zero and above-range values exercise the clamp
    rc_plan = '{0, 2, 5, 31, 16, 17, 1, 8, 0};
    rc_plan[8] = $urandom_range(0, 31);
    for (int p = 0; p < 9; p++) begin
      write_row_count(mmt_pkg::RC_W'(rc_plan[p]));
      burst = (p % 3 == 2);
      // every row a compute can touch must be fully written first
      for (int r = 0; r < cur_rows; r++)
        for (int c = 0; c < mmt_pkg::DIM; c++)
          if (!filled[r][c])
            send_item(mmt_pkg::CMD_LOAD, 4'(r), 4'(c), rand_word(), rand_word(), 1'b0, '0);
      repeat (PHASE_ITEMS) random_item();
    end

    start <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_dots.size() != 0) report("results still outstanding at the end");

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
